### rtl/core/lfse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfse_pkg
// shared types and constants of the lidar frame sample extractor
// ----------------------------------------------------------------------------
package lfse_pkg;

  localparam logic [7:0]  SyncByte   = 8'hFA;
  localparam logic [7:0]  IndexMin   = 8'hA0;
  localparam logic [7:0]  IndexMax   = 8'hDB;
  localparam logic [8:0]  TopAngle   = 9'd359;
  localparam logic [5:0]  PosIndex   = 6'd1;
  localparam logic [5:0]  PosSpeedLo = 6'd2;
  localparam logic [5:0]  PosSpeedHi = 6'd3;
  localparam logic [5:0]  PosDataLo  = 6'd4;
  localparam logic [5:0]  PosDataHi  = 6'd39;
  localparam logic [5:0]  PosLast    = 6'd41;
  localparam logic [2:0]  OffLast    = 3'd5;
  localparam logic [2:0]  SetLast    = 3'd5;
  localparam logic [15:0] RpmRecip   = 16'hCCCD;
  localparam int unsigned RpmShift   = 19;
  localparam int unsigned RpmW       = 13;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    OP_INDEX,
    OP_SPEED_LO,
    OP_SPEED_HI,
    OP_INT_LO,
    OP_INT_HI,
    OP_RANGE_LO,
    OP_RANGE_HI
  } lfse_op_e;

  typedef struct packed {
    lfse_op_e   op;
    logic [7:0] data;
    logic [2:0] set_idx;
  } lfse_cmd_t;

endpackage

### rtl/core/lfse_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfse_byte_if
// serial byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface lfse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/lfse_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfse_sample_if
// sample channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface lfse_sample_if;
  logic        valid;
  logic        ready;
  logic [8:0]  angle_deg;
  logic [15:0] range_mm;
  logic [15:0] intensity;
  logic [12:0] rpm;
  logic        last_of_frame;

  modport source (output valid, output angle_deg, output range_mm, output intensity,
                  output rpm, output last_of_frame, input ready);
  modport sink   (input valid, input angle_deg, input range_mm, input intensity,
                  input rpm, input last_of_frame, output ready);
endinterface

### rtl/core/lfse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfse_front
// frame tracker: finds sync, counts frame bytes and tags each useful byte
// ----------------------------------------------------------------------------
module lfse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  lfse_byte_if.sink         rx_i,
  input  logic              full_i,
  output logic              push_o,
  output lfse_pkg::lfse_cmd_t cmd_o
);
  import lfse_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [5:0] pos_q, pos_d;
  logic [2:0] off_q, off_d;
  logic [2:0] set_q, set_d;
  logic       accept;
  logic       in_data;
  logic       tag;

  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign in_data    = (pos_q >= PosDataLo) && (pos_q <= PosDataHi);

  always_comb begin
    tag           = 1'b0;
    cmd_o.op      = OP_INDEX;
    cmd_o.data    = rx_i.rx_byte;
    cmd_o.set_idx = set_q;
    if (in_frame_q) begin
      if (pos_q == PosIndex) begin
        tag = 1'b1;
        cmd_o.op = OP_INDEX;
      end else if (pos_q == PosSpeedLo) begin
        tag = 1'b1;
        cmd_o.op = OP_SPEED_LO;
      end else if (pos_q == PosSpeedHi) begin
        tag = 1'b1;
        cmd_o.op = OP_SPEED_HI;
      end else if (in_data) begin
        unique case (off_q)
          3'd0: begin
            tag = 1'b1;
            cmd_o.op = OP_INT_LO;
          end
          3'd1: begin
            tag = 1'b1;
            cmd_o.op = OP_INT_HI;
          end
          3'd2: begin
            tag = 1'b1;
            cmd_o.op = OP_RANGE_LO;
          end
          3'd3: begin
            tag = 1'b1;
            cmd_o.op = OP_RANGE_HI;
          end
          default: tag = 1'b0;
        endcase
      end
    end
  end

  assign push_o = accept && tag;

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    off_d      = off_q;
    set_d      = set_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_i.rx_byte == SyncByte) begin
          in_frame_d = 1'b1;
          pos_d      = PosIndex;
        end
      end else begin
        if (pos_q == PosSpeedHi) begin
          off_d = '0;
          set_d = '0;
        end else if (in_data) begin
          if (off_q == OffLast) begin
            off_d = '0;
            set_d = set_q + 3'd1;
          end else begin
            off_d = off_q + 3'd1;
          end
        end
        if (pos_q >= PosLast) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      off_q      <= '0;
      set_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      off_q      <= off_d;
      set_q      <= set_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (pos_q >= PosIndex && pos_q <= PosLast))
    else $error("frame position out of range");

  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (pos_q == '0))
    else $error("position not cleared while idle");

  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_frame_q && in_data) |-> (off_q <= OffLast && set_q <= SetLast))
    else $error("set or offset counter out of range");

endmodule

### rtl/core/lfse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfse_queue
// short command queue between frame tracker and sample builder
// ----------------------------------------------------------------------------
module lfse_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lfse_pkg::lfse_cmd_t cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output lfse_pkg::lfse_cmd_t cmd_o,
  input  logic                pop_i
);
  import lfse_pkg::*;

  lfse_cmd_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count exceeds depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != QueueCntW'(QueueDepth))
      |-> (QueuePtrW'(wr_ptr_q - rd_ptr_q) == cnt_q[QueuePtrW-1:0]))
    else $error("queue pointers and count disagree");

endmodule

### rtl/core/lfse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfse_back
// sample builder: keeps frame fields and drives the sample output register
// ----------------------------------------------------------------------------
module lfse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  lfse_pkg::lfse_cmd_t cmd_i,
  output logic                pop_o,
  lfse_sample_if.source       smp_o
);
  import lfse_pkg::*;

  logic        seg_valid_q, seg_valid_d;
  logic [5:0]  seg_num_q, seg_num_d;
  logic [7:0]  spd_lo_q, spd_lo_d;
  logic [31:0] prod_q, prod_d;
  logic [15:0] int_q, int_d;
  logic [7:0]  rng_lo_q, rng_lo_d;

  logic        out_valid_q, out_valid_d;
  logic [8:0]  angle_q, angle_d;
  logic [15:0] range_q, range_d;
  logic [15:0] inten_q, inten_d;
  logic [12:0] rpm_q, rpm_d;
  logic        last_q, last_d;

  logic        emit;
  logic        slot_free;
  logic [12:0] cur_rpm;
  logic [8:0]  angle_calc;

  assign slot_free = !out_valid_q || smp_o.ready;
  assign emit      = valid_i && (cmd_i.op == OP_RANGE_HI) && seg_valid_q;
  assign pop_o     = valid_i && (!emit || slot_free);
  assign cur_rpm   = prod_q[RpmShift +: RpmW];
  assign angle_calc = TopAngle - (9'(seg_num_q) << 2) - (9'(seg_num_q) << 1)
                      - 9'(cmd_i.set_idx);

  always_comb begin
    seg_valid_d = seg_valid_q;
    seg_num_d   = seg_num_q;
    spd_lo_d    = spd_lo_q;
    prod_d      = prod_q;
    int_d       = int_q;
    rng_lo_d    = rng_lo_q;
    if (pop_o) begin
      unique case (cmd_i.op)
        OP_INDEX: begin
          if (cmd_i.data >= IndexMin && cmd_i.data <= IndexMax) begin
            seg_valid_d = 1'b1;
            seg_num_d   = 6'(cmd_i.data - IndexMin);
          end else begin
            seg_valid_d = 1'b0;
            seg_num_d   = '0;
          end
        end
        OP_SPEED_LO: spd_lo_d = cmd_i.data;
        OP_SPEED_HI: prod_d   = {cmd_i.data, spd_lo_q} * RpmRecip;
        OP_INT_LO:   int_d    = {8'h00, cmd_i.data};
        OP_INT_HI:   int_d    = {cmd_i.data, int_q[7:0]};
        OP_RANGE_LO: rng_lo_d = cmd_i.data;
        OP_RANGE_HI: rng_lo_d = rng_lo_q;
        default:     rng_lo_d = rng_lo_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    angle_d     = angle_q;
    range_d     = range_q;
    inten_d     = inten_q;
    rpm_d       = rpm_q;
    last_d      = last_q;
    if (smp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit && slot_free) begin
      out_valid_d = 1'b1;
      angle_d     = angle_calc;
      range_d     = {cmd_i.data, rng_lo_q};
      inten_d     = int_q;
      rpm_d       = cur_rpm;
      last_d      = (cmd_i.set_idx == SetLast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_valid_q <= 1'b0;
      seg_num_q   <= '0;
      spd_lo_q    <= '0;
      prod_q      <= '0;
      int_q       <= '0;
      rng_lo_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seg_valid_q <= seg_valid_d;
      seg_num_q   <= seg_num_d;
      spd_lo_q    <= spd_lo_d;
      prod_q      <= prod_d;
      int_q       <= int_d;
      rng_lo_q    <= rng_lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
    range_q <= range_d;
    inten_q <= inten_d;
    rpm_q   <= rpm_d;
    last_q  <= last_d;
  end

  assign smp_o.valid         = out_valid_q;
  assign smp_o.angle_deg     = angle_q;
  assign smp_o.range_mm      = range_q;
  assign smp_o.intensity     = inten_q;
  assign smp_o.rpm           = rpm_q;
  assign smp_o.last_of_frame = last_q;

  a_seg_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_q |-> (seg_num_q <= 6'd59))
    else $error("segment number out of range");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (angle_q <= TopAngle))
    else $error("angle out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !slot_free) |-> !pop_o)
    else $error("sample command popped while output is blocked");

endmodule

### rtl/core/lidar_frame_sample_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_sample_extractor_unit
// parses 42-byte sensor frames and, for a frame with a valid index, emits one sample per range reading
// ----------------------------------------------------------------------------
// path: the range high byte passes the queue entry and then the output register before its sample is on smp_o
// throughput: one byte per cycle while the queue is not full, set by the single-entry pop of the queue
// one sample at most every 6 bytes, held in an output register
// reset: all control cleared, waits for a sync byte, rpm product reads 0 until set
// ----------------------------------------------------------------------------
module lidar_frame_sample_extractor_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  lfse_byte_if.sink     rx_i,
  lfse_sample_if.source smp_o
);
  import lfse_pkg::*;

  logic      push;
  logic      full;
  lfse_cmd_t push_cmd;
  logic      q_valid;
  lfse_cmd_t q_cmd;
  logic      pop;

  lfse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  lfse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  lfse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (q_cmd),
    .pop_o   (pop),
    .smp_o   (smp_o)
  );

endmodule
